### hdl/adjacency_matrix_graph_traversal_macros.svh
// Assertion macros for the graph traversal block.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef ADJACENCY_MATRIX_GRAPH_TRAVERSAL_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_TRAVERSAL_MACROS_SVH

// Same-cycle implication.
`define AMGT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amgt: implication check failed");

// Next-cycle implication.
`define AMGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amgt: next-cycle check failed");

`endif

### hdl/amgt_pkg.sv
// Shared types and codes for the graph traversal block.
// No dependencies; imported by the controller, the datapath, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package amgt_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int NW = 6;

  typedef enum logic [3:0] {
    OP_ADD_VERTEX  = 4'd0,
    OP_ADD_EDGE    = 4'd1,
    OP_REMOVE_EDGE = 4'd2,
    OP_TEST_EDGE   = 4'd3,
    OP_READ_LABEL  = 4'd4,
    OP_WRITE_LABEL = 4'd5,
    OP_NEIGHBOURS  = 4'd6,
    OP_BFS         = 4'd7,
    OP_DFS         = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RRS_S, RRS_I, RRS_CURV, RRS_QDATA
  } row_rsel_t;

  typedef enum logic [1:0] {
    RWS_EDGE, RWS_CLRCOL, RWS_ZERO
  } row_wsel_t;

  typedef enum logic [1:0] {
    RVS_HOLD, RVS_S, RVS_I, RVS_CNT
  } rv_sel_t;

  typedef enum logic [2:0] {
    RK_VISIT, RK_EDGE, RK_ERR_IDX, RK_ERR_FULL, RK_EMPTY
  } res_kind_t;

  typedef struct packed {
    logic [4:0]  vertex;
    logic [31:0] label;
    logic        edge_bit;
    logic [1:0]  status;
    logic        item;
  } res_t;

  typedef struct packed {
    logic      load;
    logic      row_rd;
    row_rsel_t row_rsel;
    logic      row_wr;
    row_wsel_t row_wsel;
    logic      lab_rd;
    logic      lab_wr;
    logic      lab_wsel_s;
    logic      rv_ld;
    rv_sel_t   rv_sel;
    logic      i_clr;
    logic      i_inc;
    logic      vcount_inc;
    logic      vis_init;
    logic      vis_set;
    logic      q_init;
    logic      q_push;
    logic      q_pop;
    logic      stk_clr;
    logic      stk_push;
    logic      stk_pop;
    logic      stk_load;
    logic      curv_init;
    logic      curv_ld_i;
    logic      res_ld;
    res_kind_t res_kind;
    logic      push;
    logic      flush;
  } amgt_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       s_bad;
    logic       t_bad;
    logic       full;
    logic       scan_end;
    logic       hit_nb;
    logic       hit_new;
    logic       q_empty;
    logic       sp_zero;
    logic       n_max;
    logic       n_zero;
    logic       pend_valid;
    logic       out_valid;
  } amgt_stat_t;

endpackage

### hdl/amgt_datapath.sv
// Datapath: adjacency row and label memories, visit marks, walk queue and stack,
// scan counter and the pending/output result registers. Depends on amgt_pkg.
`timescale 1ns / 1ps

module amgt_datapath import amgt_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int LABEL_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  operation,
  input  logic [4:0]  source_vertex,
  input  logic [4:0]  target_vertex,
  input  logic [31:0] label_value,
  input  amgt_cmd_t   cmd,
  output amgt_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  vertex_index,
  output logic [31:0] label_out,
  output logic        edge_present,
  output logic [1:0]  status,
  output logic        has_item,
  output logic        last
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam int MW = MAX_VERTICES;
  localparam int LW = LABEL_WIDTH;

  logic [3:0]    op_r;
  logic [4:0]    s_r;
  logic [4:0]    t_r;
  logic [LW-1:0] lab_r;
  logic [CW-1:0] vcount;

  logic [MW-1:0] rows [MW];
  logic [MW-1:0] row_q;
  logic [LW-1:0] labs [MW];
  logic [LW-1:0] lab_q;
  logic [MW-1:0] visited;

  logic [VW-1:0] qmem [MW];
  logic [VW-1:0] q_q;
  logic [CW-1:0] head;
  logic [CW-1:0] tail;

  logic [VW-1:0] stk_v [MW];
  logic [CW-1:0] stk_p [MW];
  logic [VW-1:0] stk_v_q;
  logic [CW-1:0] stk_p_q;
  logic [CW-1:0] sp;

  logic [VW-1:0] cur_v;
  logic [CW-1:0] i;
  logic [VW-1:0] rv;
  res_t          res;
  res_t          pend;
  logic          pend_valid;
  res_t          out_r;
  logic          out_last;
  logic [NW-1:0] n;

  logic [VW-1:0] s_idx;
  logic [VW-1:0] t_idx;
  logic [VW-1:0] i_idx;
  logic [VW-1:0] rv_src;
  logic [VW-1:0] row_raddr;
  logic [VW-1:0] row_waddr;
  logic [MW-1:0] row_wdata;
  logic [MW-1:0] edge_row;
  logic [MW-1:0] t_bit;
  logic [CW-1:0] sp_dec;
  res_t          res_new;

  assign s_idx  = VW'(s_r);
  assign t_idx  = VW'(t_r);
  assign i_idx  = i[VW-1:0];
  assign t_bit  = MW'(1) << t_idx;
  assign sp_dec = sp - CW'(1);

  always_comb begin
    case (cmd.rv_sel)
      RVS_S:   rv_src = s_idx;
      RVS_I:   rv_src = i_idx;
      RVS_CNT: rv_src = VW'(vcount);
      default: rv_src = rv;
    endcase
  end

  always_comb begin
    case (cmd.row_rsel)
      RRS_I:     row_raddr = i_idx;
      RRS_CURV:  row_raddr = cur_v;
      RRS_QDATA: row_raddr = q_q;
      default:   row_raddr = s_idx;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_ADD_EDGE:    edge_row = row_q | t_bit;
      OP_REMOVE_EDGE: edge_row = row_q & ~t_bit;
      default:        edge_row = row_q;
    endcase
  end

  always_comb begin
    case (cmd.row_wsel)
      RWS_EDGE: begin
        row_waddr = s_idx;
        row_wdata = edge_row;
      end
      RWS_CLRCOL: begin
        row_waddr = i_idx;
        row_wdata = row_q & ~(MW'(1) << rv);
      end
      default: begin
        row_waddr = rv;
        row_wdata = '0;
      end
    endcase
  end

  always_comb begin
    res_new = '0;
    case (cmd.res_kind)
      RK_VISIT: begin
        res_new.vertex = 5'(rv);
        res_new.label  = 32'(lab_q);
        res_new.item   = 1'b1;
      end
      RK_EDGE: begin
        res_new.vertex   = s_r;
        res_new.edge_bit = edge_row[t_idx];
        res_new.item     = 1'b1;
      end
      RK_ERR_IDX:  res_new.status = ST_BAD_INDEX;
      RK_ERR_FULL: res_new.status = ST_FULL;
      default:     res_new = '0;
    endcase
  end

  // memories: registered read data
  always_ff @(posedge clk) begin
    if (cmd.row_wr) rows[row_waddr] <= row_wdata;
    if (cmd.row_rd) row_q <= rows[row_raddr];
    if (cmd.lab_wr) labs[cmd.lab_wsel_s ? s_idx : rv] <= lab_r;
    if (cmd.lab_rd) lab_q <= labs[rv_src];
    if (cmd.q_init) qmem[0] <= s_idx;
    else if (cmd.q_push) qmem[tail[VW-1:0]] <= i_idx;
    if (cmd.q_pop) q_q <= qmem[head[VW-1:0]];
    if (cmd.stk_push) begin
      stk_v[sp[VW-1:0]] <= cur_v;
      stk_p[sp[VW-1:0]] <= i + CW'(1);
    end
    if (cmd.stk_pop) begin
      stk_v_q <= stk_v[sp_dec[VW-1:0]];
      stk_p_q <= stk_p[sp_dec[VW-1:0]];
    end
  end

  // item fields and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      s_r   <= source_vertex;
      t_r   <= target_vertex;
      lab_r <= LW'(label_value);
    end
    if (cmd.rv_ld) rv <= rv_src;
    if (cmd.i_clr) i <= '0;
    else if (cmd.stk_load) i <= stk_p_q;
    else if (cmd.i_inc) i <= i + CW'(1);
    if (cmd.curv_init) cur_v <= s_idx;
    else if (cmd.curv_ld_i) cur_v <= i_idx;
    else if (cmd.stk_load) cur_v <= stk_v_q;
    if (cmd.vis_init) visited <= MW'(1) << s_idx;
    else if (cmd.vis_set) visited[i_idx] <= 1'b1;
    if (cmd.res_ld) res <= res_new;
    if (cmd.push) pend <= res;
    if (cmd.push && pend_valid) begin
      out_r    <= pend;
      out_last <= 1'b0;
    end else if (cmd.flush) begin
      out_r    <= pend;
      out_last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= '0;
      head       <= '0;
      tail       <= '0;
      sp         <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.vcount_inc) vcount <= vcount + CW'(1);
      if (cmd.q_init) begin
        head <= '0;
        tail <= CW'(1);
      end else begin
        if (cmd.q_push) tail <= tail + CW'(1);
        if (cmd.q_pop) head <= head + CW'(1);
      end
      if (cmd.stk_clr) sp <= '0;
      else if (cmd.stk_push) sp <= sp + CW'(1);
      else if (cmd.stk_pop) sp <= sp_dec;
      if (cmd.load) n <= '0;
      else if (cmd.push) n <= n + NW'(1);
      if (cmd.push) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      // push moves pend only when the output register is free
      if ((cmd.push && pend_valid) || cmd.flush) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.op         = op_r;
    stat.s_bad      = XW'(s_r) >= XW'(vcount);
    stat.t_bad      = XW'(t_r) >= XW'(vcount);
    stat.full       = vcount == CW'(MAX_VERTICES);
    stat.scan_end   = i == vcount;
    stat.hit_nb     = row_q[i_idx];
    stat.hit_new    = row_q[i_idx] & ~visited[i_idx];
    stat.q_empty    = head == tail;
    stat.sp_zero    = sp == '0;
    stat.n_max      = n == NW'(MAX_RESULTS);
    stat.n_zero     = n == '0;
    stat.pend_valid = pend_valid;
    stat.out_valid  = out_valid;
  end

  assign vertex_index = out_r.vertex;
  assign label_out    = out_r.label;
  assign edge_present = out_r.edge_bit;
  assign status       = out_r.status;
  assign has_item     = out_r.item;
  assign last         = out_last;

endmodule

### hdl/amgt_ctrl.sv
// Controller: sequences each operation over the datapath by command strobes.
// Depends on amgt_pkg.
`timescale 1ns / 1ps

module amgt_ctrl import amgt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  amgt_stat_t stat,
  output amgt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CLR_RD, S_CLR_WR, S_LBL_RD, S_L_WAIT, S_EDGE_UPD,
    S_NB_SCAN, S_BFS_POP, S_BFS_QW, S_BFS_SCAN, S_DFS_RD, S_DFS_SCAN,
    S_DFS_POPW, S_PUSH, S_FLUSH
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_ADD_VERTEX) begin
          if (stat.full) begin
            cmd.res_ld   = 1'b1;
            cmd.res_kind = RK_ERR_FULL;
            ret_next     = S_FLUSH;
            state_next   = S_PUSH;
          end else begin
            cmd.rv_ld  = 1'b1;
            cmd.rv_sel = RVS_CNT;
            cmd.i_clr  = 1'b1;
            state_next = S_CLR_RD;
          end
        end else if (stat.op inside {OP_ADD_EDGE, OP_REMOVE_EDGE, OP_TEST_EDGE}) begin
          if (stat.s_bad || stat.t_bad) begin
            cmd.res_ld   = 1'b1;
            cmd.res_kind = RK_ERR_IDX;
            ret_next     = S_FLUSH;
            state_next   = S_PUSH;
          end else begin
            cmd.row_rd   = 1'b1;
            cmd.row_rsel = RRS_S;
            state_next   = S_EDGE_UPD;
          end
        end else if (stat.op inside {[OP_READ_LABEL:OP_DFS]}) begin
          if (stat.s_bad) begin
            cmd.res_ld   = 1'b1;
            cmd.res_kind = RK_ERR_IDX;
            ret_next     = S_FLUSH;
            state_next   = S_PUSH;
          end else begin
            case (stat.op)
              OP_READ_LABEL, OP_WRITE_LABEL: begin
                cmd.lab_wr     = stat.op == OP_WRITE_LABEL;
                cmd.lab_wsel_s = 1'b1;
                cmd.rv_ld      = 1'b1;
                cmd.rv_sel     = RVS_S;
                state_next     = S_LBL_RD;
              end
              OP_NEIGHBOURS: begin
                cmd.row_rd   = 1'b1;
                cmd.row_rsel = RRS_S;
                cmd.i_clr    = 1'b1;
                state_next   = S_NB_SCAN;
              end
              OP_BFS: begin
                cmd.vis_init = 1'b1;
                cmd.q_init   = 1'b1;
                cmd.rv_ld    = 1'b1;
                cmd.rv_sel   = RVS_S;
                cmd.lab_rd   = 1'b1;
                ret_next     = S_BFS_POP;
                state_next   = S_L_WAIT;
              end
              default: begin
                cmd.vis_init  = 1'b1;
                cmd.curv_init = 1'b1;
                cmd.i_clr     = 1'b1;
                cmd.stk_clr   = 1'b1;
                cmd.rv_ld     = 1'b1;
                cmd.rv_sel    = RVS_S;
                cmd.lab_rd    = 1'b1;
                ret_next      = S_DFS_RD;
                state_next    = S_L_WAIT;
              end
            endcase
          end
        end else begin
          // unused codes: drop silently
          state_next = S_IDLE;
        end
      end
      S_CLR_RD: begin
        if (stat.scan_end) begin
          cmd.row_wr     = 1'b1;
          cmd.row_wsel   = RWS_ZERO;
          cmd.lab_wr     = 1'b1;
          cmd.vcount_inc = 1'b1;
          state_next     = S_LBL_RD;
        end else begin
          cmd.row_rd   = 1'b1;
          cmd.row_rsel = RRS_I;
          state_next   = S_CLR_WR;
        end
      end
      S_CLR_WR: begin
        cmd.row_wr   = 1'b1;
        cmd.row_wsel = RWS_CLRCOL;
        cmd.i_inc    = 1'b1;
        state_next   = S_CLR_RD;
      end
      S_LBL_RD: begin
        cmd.lab_rd = 1'b1;
        cmd.rv_sel = RVS_HOLD;
        ret_next   = S_FLUSH;
        state_next = S_L_WAIT;
      end
      S_L_WAIT: begin
        cmd.res_ld   = 1'b1;
        cmd.res_kind = RK_VISIT;
        state_next   = S_PUSH;
      end
      S_EDGE_UPD: begin
        cmd.row_wr   = 1'b1;
        cmd.row_wsel = RWS_EDGE;
        cmd.res_ld   = 1'b1;
        cmd.res_kind = RK_EDGE;
        ret_next     = S_FLUSH;
        state_next   = S_PUSH;
      end
      S_NB_SCAN: begin
        if (stat.n_max) begin
          state_next = S_FLUSH;
        end else if (stat.scan_end) begin
          if (stat.n_zero) begin
            cmd.res_ld   = 1'b1;
            cmd.res_kind = RK_EMPTY;
            ret_next     = S_FLUSH;
            state_next   = S_PUSH;
          end else begin
            state_next = S_FLUSH;
          end
        end else if (stat.hit_nb) begin
          cmd.rv_ld  = 1'b1;
          cmd.rv_sel = RVS_I;
          cmd.lab_rd = 1'b1;
          cmd.i_inc  = 1'b1;
          ret_next   = S_NB_SCAN;
          state_next = S_L_WAIT;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_BFS_POP: begin
        if (stat.n_max || stat.q_empty) begin
          state_next = S_FLUSH;
        end else begin
          cmd.q_pop  = 1'b1;
          state_next = S_BFS_QW;
        end
      end
      S_BFS_QW: begin
        cmd.row_rd   = 1'b1;
        cmd.row_rsel = RRS_QDATA;
        cmd.i_clr    = 1'b1;
        state_next   = S_BFS_SCAN;
      end
      S_BFS_SCAN: begin
        if (stat.n_max) begin
          state_next = S_FLUSH;
        end else if (stat.scan_end) begin
          state_next = S_BFS_POP;
        end else if (stat.hit_new) begin
          cmd.vis_set = 1'b1;
          cmd.q_push  = 1'b1;
          cmd.rv_ld   = 1'b1;
          cmd.rv_sel  = RVS_I;
          cmd.lab_rd  = 1'b1;
          cmd.i_inc   = 1'b1;
          ret_next    = S_BFS_SCAN;
          state_next  = S_L_WAIT;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_DFS_RD: begin
        cmd.row_rd   = 1'b1;
        cmd.row_rsel = RRS_CURV;
        state_next   = S_DFS_SCAN;
      end
      S_DFS_SCAN: begin
        if (stat.n_max) begin
          state_next = S_FLUSH;
        end else if (stat.scan_end) begin
          if (stat.sp_zero) begin
            state_next = S_FLUSH;
          end else begin
            cmd.stk_pop = 1'b1;
            state_next  = S_DFS_POPW;
          end
        end else if (stat.hit_new) begin
          // save resume point, then descend into the new vertex
          cmd.stk_push  = 1'b1;
          cmd.vis_set   = 1'b1;
          cmd.curv_ld_i = 1'b1;
          cmd.rv_ld     = 1'b1;
          cmd.rv_sel    = RVS_I;
          cmd.lab_rd    = 1'b1;
          cmd.i_clr     = 1'b1;
          ret_next      = S_DFS_RD;
          state_next    = S_L_WAIT;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_DFS_POPW: begin
        cmd.stk_load = 1'b1;
        state_next   = S_DFS_RD;
      end
      S_PUSH: begin
        if (!stat.pend_valid || !stat.out_valid) begin
          cmd.push   = 1'b1;
          state_next = ret;
        end
      end
      S_FLUSH: begin
        if (!stat.out_valid) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

### hdl/adjacency_matrix_graph_traversal.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    operation, source_vertex, target_vertex, label_value
// output    out_valid / out_ready  vertex_index, label_out, edge_present, status,
//                                  has_item, last
//
// One item at a time: a new operation is accepted only after the last one has
// finished. Add vertex clears the new column with one read-modify-write of each
// existing matrix row and zeroes the new row; neighbours and traversals scan
// each matrix row that they read one entry at a time.
// Results leave through a one-deep pending register and an output register, so a
// stalled output holds the controller. No clearing pass after reset.
`timescale 1ns / 1ps
`include "adjacency_matrix_graph_traversal_macros.svh"

module adjacency_matrix_graph_traversal import amgt_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int LABEL_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [4:0]  source_vertex,
  input  logic [4:0]  target_vertex,
  input  logic [31:0] label_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  vertex_index,
  output logic [31:0] label_out,
  output logic        edge_present,
  output logic [1:0]  status,
  output logic        has_item,
  output logic        last
);

  amgt_cmd_t  cmd;
  amgt_stat_t stat;

  amgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  amgt_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .LABEL_WIDTH  (LABEL_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .operation     (operation),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .label_value   (label_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vertex_index  (vertex_index),
    .label_out     (label_out),
    .edge_present  (edge_present),
    .status        (status),
    .has_item      (has_item),
    .last          (last)
  );

  `AMGT_ASSERT_IMP(a_idle_no_pending, in_ready, !stat.pend_valid)
  `AMGT_ASSERT_IMP(a_push_has_room, cmd.push, !stat.pend_valid || !stat.out_valid)
  `AMGT_ASSERT_IMP(a_flush_has_result, cmd.flush, stat.pend_valid && !stat.out_valid)
  `AMGT_ASSERT_NEXT(a_push_fills_pending, cmd.push, stat.pend_valid)

endmodule

### verif/graph_checker.sv
// Checker for the adjacency matrix graph block: watches both channels,
// predicts the result transactions of each accepted operation and compares them.
// Depends on amgt_pkg for the operation and status codes.
`timescale 1ns / 1ps

module graph_checker import amgt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [4:0]  source_vertex,
  input  logic [4:0]  target_vertex,
  input  logic [31:0] label_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  vertex_index,
  input  logic [31:0] label_out,
  input  logic        edge_present,
  input  logic [1:0]  status,
  input  logic        has_item,
  input  logic        last,
  output int          failures,
  output int          pending,
  output int          results_seen,
  output int          traversals_seen,
  output logic [5:0]  graph_size
);

  typedef struct packed {
    logic [4:0]  vertex;
    logic [31:0] label;
    logic        edge_bit;
    logic [1:0]  status;
    logic        item;
    logic        last;
  } graph_result_t;

  graph_result_t result_queue[$];
  logic [31:0] adj_row[32];
  logic [31:0] vlabel[32];
  logic [5:0]  nverts;

  assign pending = result_queue.size();
  assign graph_size = nverts;

  function automatic graph_result_t make_res(logic [4:0] v, logic [31:0] lab, logic e,
                                             logic [1:0] st, logic it, logic lst);
    graph_result_t r;
    r.vertex = v; r.label = lab; r.edge_bit = e; r.status = st; r.item = it; r.last = lst;
    return r;
  endfunction

  task automatic push_visit(inout int n, input logic [4:0] v);
    if (n < MAX_RESULTS) begin
      result_queue.push_back(make_res(v, vlabel[v], 1'b0, ST_OK, 1'b1, 1'b0));
      n++;
    end
  endtask

  task automatic predict_operation(logic [3:0] op, logic [4:0] s, logic [4:0] t,
                                   logic [31:0] lab);
    int n;
    int head;
    int tail;
    int depth;
    int k;
    int j;
    int v;
    logic [31:0] seen;
    logic [4:0] fifo[64];
    logic [4:0] stk_v[64];
    int stk_p[64];
    logic found;
    n = 0;
    if (op > OP_DFS) return;
    if (op == OP_ADD_VERTEX) begin
      if (nverts >= 32) begin
        result_queue.push_back(make_res('0, '0, 1'b0, ST_FULL, 1'b0, 1'b1));
        return;
      end
      for (k = 0; k < nverts; k++) adj_row[k][nverts] = 1'b0;
      adj_row[nverts] = '0;
      vlabel[nverts] = lab;
      result_queue.push_back(make_res(nverts[4:0], lab, 1'b0, ST_OK, 1'b1, 1'b1));
      nverts++;
      return;
    end
    if (op inside {OP_ADD_EDGE, OP_REMOVE_EDGE, OP_TEST_EDGE}) begin
      if (s >= nverts || t >= nverts) begin
        result_queue.push_back(make_res('0, '0, 1'b0, ST_BAD_INDEX, 1'b0, 1'b1));
        return;
      end
      if (op == OP_ADD_EDGE) adj_row[s][t] = 1'b1;
      else if (op == OP_REMOVE_EDGE) adj_row[s][t] = 1'b0;
      result_queue.push_back(make_res(s, '0, adj_row[s][t], ST_OK, 1'b1, 1'b1));
      return;
    end
    if (s >= nverts) begin
      result_queue.push_back(make_res('0, '0, 1'b0, ST_BAD_INDEX, 1'b0, 1'b1));
      return;
    end
    if (op == OP_READ_LABEL || op == OP_WRITE_LABEL) begin
      if (op == OP_WRITE_LABEL) vlabel[s] = lab;
      result_queue.push_back(make_res(s, vlabel[s], 1'b0, ST_OK, 1'b1, 1'b1));
      return;
    end
    if (op == OP_NEIGHBOURS) begin
      for (k = 0; k < nverts; k++)
        if (adj_row[s][k]) push_visit(n, k[4:0]);
      if (n == 0) begin
        result_queue.push_back(make_res('0, '0, 1'b0, ST_OK, 1'b0, 1'b1));
        return;
      end
      result_queue[$].last = 1'b1;
      return;
    end
    seen = '0;
    seen[s] = 1'b1;
    push_visit(n, s);
    if (op == OP_BFS) begin
      head = 0; tail = 1; fifo[0] = s;
      while (head != tail) begin
        v = fifo[head]; head++;
        for (k = 0; k < nverts; k++)
          if (adj_row[v][k] && !seen[k]) begin
            seen[k] = 1'b1;
            push_visit(n, k[4:0]);
            fifo[tail] = k[4:0]; tail++;
          end
      end
    end else begin
      depth = 1; stk_v[0] = s; stk_p[0] = 0;
      while (depth > 0) begin
        v = stk_v[depth-1];
        found = 1'b0;
        j = 0;
        for (k = stk_p[depth-1]; k < nverts && !found; k++)
          if (adj_row[v][k] && !seen[k]) begin
            found = 1'b1; j = k;
          end
        if (found) begin
          stk_p[depth-1] = j + 1;
          seen[j] = 1'b1;
          push_visit(n, j[4:0]);
          stk_v[depth] = j[4:0]; stk_p[depth] = 0;
          depth++;
        end else begin
          depth--;
        end
      end
    end
    result_queue[$].last = 1'b1;
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    graph_result_t exp_r;
    if (rst) begin
      nverts = '0;
      failures = 0;
      results_seen = 0;
      traversals_seen = 0;
      result_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_queue.size() == 0) begin
          $error("result transaction with nothing expected (vertex %0d)", vertex_index);
          failures++;
        end else begin
          exp_r = result_queue.pop_front();
          compare_field("vertex_index", exp_r.vertex, vertex_index);
          compare_field("label_out", exp_r.label, label_out);
          compare_field("edge_present", exp_r.edge_bit, edge_present);
          compare_field("status", exp_r.status, status);
          compare_field("has_item", exp_r.item, has_item);
          compare_field("last", exp_r.last, last);
        end
      end
      if (in_valid && in_ready) begin
        if (operation == OP_BFS || operation == OP_DFS) traversals_seen++;
        predict_operation(operation, source_vertex, target_vertex, label_value);
      end
    end
  end

endmodule

### verif/testbench.sv
// Top of the graph block testbench: clock, reset, stimulus and verdict.
// Depends on amgt_pkg, the block adjacency_matrix_graph_traversal and graph_checker.
`timescale 1ns / 1ps

module testbench;
  import amgt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  operation;
  logic [4:0]  source_vertex;
  logic [4:0]  target_vertex;
  logic [31:0] label_value;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  vertex_index;
  logic [31:0] label_out;
  logic        edge_present;
  logic [1:0]  status;
  logic        has_item;
  logic        last;
  int          failures;
  int          pending;
  int          results_seen;
  int          traversals_seen;
  logic [5:0]  graph_size;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;
  int          items_sent;

  adjacency_matrix_graph_traversal i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .source_vertex(source_vertex),
    .target_vertex(target_vertex), .label_value(label_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_index(vertex_index), .label_out(label_out),
    .edge_present(edge_present), .status(status),
    .has_item(has_item), .last(last)
  );

  graph_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .source_vertex(source_vertex),
    .target_vertex(target_vertex), .label_value(label_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_index(vertex_index), .label_out(label_out),
    .edge_present(edge_present), .status(status),
    .has_item(has_item), .last(last),
    .failures(failures), .pending(pending), .results_seen(results_seen),
    .traversals_seen(traversals_seen), .graph_size(graph_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Valid stays high after acceptance until the next idle cycle or the next transaction.
  task automatic send_op(logic [3:0] op, logic [4:0] s, logic [4:0] t, logic [31:0] lab);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    source_vertex <= s;
    target_vertex <= t;
    label_value   <= lab;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Mostly valid indices so edges and traversals get exercised; a few out of range.
  task automatic send_random_op();
    logic [3:0] op;
    logic [4:0] s;
    logic [4:0] t;
    int r;
    r = $urandom_range(99);
    if (r < 4) op = 4'($urandom_range(15, 9));
    else if (r < 10) op = OP_ADD_VERTEX;
    else if (r < 40) op = OP_ADD_EDGE;
    else if (r < 48) op = OP_REMOVE_EDGE;
    else if (r < 56) op = OP_TEST_EDGE;
    else if (r < 62) op = OP_READ_LABEL;
    else if (r < 68) op = OP_WRITE_LABEL;
    else if (r < 76) op = OP_NEIGHBOURS;
    else if (r < 88) op = OP_BFS;
    else op = OP_DFS;
    if (graph_size != 0 && $urandom_range(9) != 0) begin
      s = 5'($urandom_range(graph_size - 1));
      t = 5'($urandom_range(graph_size - 1));
    end else begin
      s = 5'($urandom);
      t = 5'($urandom);
    end
    send_op(op, s, t, $urandom);
  endtask

  initial begin
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0;
    source_vertex = '0;
    target_vertex = '0;
    label_value = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    items_sent = 0;
    send_idle_pct = 36;
    recv_idle_pct = 51;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: errors on an empty graph, then a small graph with every operation.
    send_op(OP_READ_LABEL, 5'd0, 5'd0, 32'h0);
    send_op(OP_BFS, 5'd31, 5'd0, 32'h0);
    send_op(OP_ADD_EDGE, 5'd0, 5'd0, 32'h0);
    send_op(OP_ADD_VERTEX, 5'd31, 5'd31, 32'hFFFF_FFFF);
    send_op(OP_ADD_VERTEX, 5'd0, 5'd0, 32'h0);
    send_op(OP_ADD_VERTEX, 5'd0, 5'd0, 32'hA5A5_5A5A);
    send_op(OP_NEIGHBOURS, 5'd0, 5'd0, 32'h0);
    send_op(OP_ADD_EDGE, 5'd0, 5'd2, 32'h0);
    send_op(OP_ADD_EDGE, 5'd0, 5'd1, 32'h0);
    send_op(OP_ADD_EDGE, 5'd2, 5'd0, 32'h0);
    send_op(OP_ADD_EDGE, 5'd1, 5'd1, 32'h0);
    send_op(OP_TEST_EDGE, 5'd2, 5'd0, 32'h0);
    send_op(OP_TEST_EDGE, 5'd0, 5'd31, 32'h0);
    send_op(OP_REMOVE_EDGE, 5'd1, 5'd1, 32'h0);
    send_op(OP_WRITE_LABEL, 5'd1, 5'd0, 32'h1234_5678);
    send_op(OP_READ_LABEL, 5'd1, 5'd0, 32'h0);
    send_op(OP_NEIGHBOURS, 5'd0, 5'd0, 32'h0);
    send_op(OP_BFS, 5'd2, 5'd0, 32'h0);
    send_op(OP_DFS, 5'd0, 5'd0, 32'h0);
    send_op(4'd15, 5'd31, 5'd31, 32'hFFFF_FFFF);
    send_op(4'd9, 5'd0, 5'd0, 32'h0);

    // Hold the sender until every expected transaction has drained.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Fill the graph to capacity, then one more to hit the full case.
    while (graph_size < 32) send_op(OP_ADD_VERTEX, 5'($urandom), 5'($urandom), $urandom);
    send_op(OP_ADD_VERTEX, 5'd0, 5'd0, 32'h0);
    for (k = 0; k < 40; k++) send_random_op();
    send_op(OP_BFS, 5'd0, 5'd0, 32'h0);
    send_op(OP_DFS, 5'd31, 5'd0, 32'h0);

    send_idle_pct = 51;
    recv_idle_pct = 36;
    for (k = 0; k < 37; k++) send_random_op();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < 37; k++) send_random_op();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d operations, %0d traversals and %0d result transactions.",
             items_sent, traversals_seen, results_seen);
    if (failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/amgt_pkg.sv
hdl/amgt_datapath.sv
hdl/amgt_ctrl.sv
hdl/adjacency_matrix_graph_traversal.sv
verif/graph_checker.sv
verif/testbench.sv
